// ----- rtl/tsg_pkg.sv -----
// ----------------------------------------------------------------------------
// tsg_pkg
// Shared types, constants and the axis decoder of the touch slider gesture
// recognizer.
// ----------------------------------------------------------------------------
package tsg_pkg;

  localparam int X_ELECTRODES = 8;
  localparam int Y_ELECTRODES = 4;

  localparam logic [7:0] F_TOUCH = 8'h01;
  localparam logic [7:0] F_REL   = 8'h02;
  localparam logic [7:0] F_MOVE  = 8'h04;
  localparam logic [7:0] F_TAP   = 8'h08;
  localparam logic [7:0] F_PRESS = 8'h10;
  localparam logic [7:0] F_HOLD  = 8'h20;
  localparam logic [7:0] F_SWIPE = 8'h40;
  localparam logic [7:0] F_DRAG  = 8'h80;

  localparam logic [15:0] SUM_MAX = 16'd32767;

  typedef enum logic [2:0] {
    REG_MIN_X,
    REG_MAX_X,
    REG_MIN_Y,
    REG_MAX_Y,
    REG_INVERT_X,
    REG_INVERT_Y,
    REG_EDGE_ZONE
  } reg_index_t;

  typedef struct packed {
    logic [4:0] min_x;
    logic [5:0] max_x;
    logic [4:0] min_y;
    logic [5:0] max_y;
    logic       invert_x;
    logic       invert_y;
  } cfg_t;

  typedef struct packed {
    logic [5:0]        cur_x;
    logic [5:0]        cur_y;
    logic [5:0]        begin_x;
    logic [5:0]        begin_y;
    logic [15:0]       pos_sum_x;
    logic [15:0]       pos_sum_y;
    logic [15:0]       neg_sum_x;
    logic [15:0]       neg_sum_y;
    logic signed [15:0] swipe_dx;
    logic signed [15:0] swipe_dy;
    logic [31:0]       touch_time;
    logic [31:0]       release_time;
    logic [31:0]       held_time;
    logic [31:0]       last_tap_time;
    logic [31:0]       last_press_time;
    logic [7:0]        repeat_count;
    logic [7:0]        pending_flags;
    logic              tap_armed;
    logic              press_armed;
  } state_t;

  typedef struct packed {
    logic [7:0]         event_flags;
    logic [5:0]         pos_x;
    logic [5:0]         pos_y;
    logic [5:0]         start_x;
    logic [5:0]         start_y;
    logic signed [15:0] swipe_x;
    logic signed [15:0] swipe_y;
    logic [7:0]         tap_count;
    logic [31:0]        duration_ms;
  } result_t;

  // Decodes one axis mask. The highest touched electrode run wins, a pair of
  // neighbors gives the half step, and the second highest electrode alone
  // forces the override value.
  function automatic logic [5:0] decode_axis(input logic [7:0] mask, input int n,
                                             input logic signed [9:0] single,
                                             input logic signed [9:0] dbl,
                                             input logic signed [9:0] ovr,
                                             input logic signed [9:0] lo,
                                             input logic signed [9:0] hi,
                                             input logic inv);
    logic signed [9:0] v;
    logic a;
    logic b;
    logic [5:0] r;
    v = -10'sd1;
    for (int i = 0; i < 8; i++) begin
      a = mask[i];
      b = (i == 0) ? 1'b0 : mask[(i == 0) ? 0 : i - 1];
      if (i < n) begin
        if (a && !b) v = single + $signed(10'(2 * i));
        if (a && b) v = dbl + $signed(10'(2 * i));
      end
    end
    if (mask[n - 2] && !mask[n - 1]) v = ovr;
    if (v >= lo && inv) v = hi + lo - v;
    if (v < lo) r = 6'd0;
    else if (v > 10'sd63) r = 6'd63;
    else r = v[5:0];
    return r;
  endfunction

endpackage

// ----- rtl/tsg_classify.sv -----
// ----------------------------------------------------------------------------
// tsg_classify
// Gesture classification: tap, press, hold, swipe and drag, repeat counting.
// ----------------------------------------------------------------------------
module tsg_classify (
  input  tsg_pkg::state_t st_in,
  input  logic [31:0]     now,
  input  logic [31:0]     dur,
  output tsg_pkg::state_t st_out
);

  logic              rel;
  logic signed [16:0] mx;
  logic signed [16:0] my;
  logic signed [18:0] mx3;
  logic signed [18:0] my3;
  logic              still;
  logic              swipe_any;

  assign rel = st_in.pending_flags[1];
  assign mx  = $signed({1'b0, st_in.pos_sum_x}) - $signed({1'b0, st_in.neg_sum_x});
  assign my  = $signed({1'b0, st_in.pos_sum_y}) - $signed({1'b0, st_in.neg_sum_y});
  assign mx3 = ($signed({{2{mx[16]}}, mx}) <<< 1) + $signed({{2{mx[16]}}, mx});
  assign my3 = ($signed({{2{my[16]}}, my}) <<< 1) + $signed({{2{my[16]}}, my});
  assign still = st_in.pos_sum_x <= 16'd5 && st_in.neg_sum_x <= 16'd5 && mx <= 17'sd2 &&
                 st_in.pos_sum_y <= 16'd5 && st_in.neg_sum_y <= 16'd5 && my <= 17'sd2;

  always_comb begin
    st_out = st_in;
    if (still) begin
      if (rel) begin
        if (dur <= 32'd1000) begin
          st_out.pending_flags = st_out.pending_flags | tsg_pkg::F_TAP;
          if (st_in.tap_armed && st_in.repeat_count != 8'd255) begin
            st_out.repeat_count = st_in.repeat_count + 8'd1;
          end
          st_out.last_tap_time = now;
          st_out.tap_armed = 1'b1;
          st_out.press_armed = 1'b0;
        end else begin
          st_out.pending_flags = st_out.pending_flags | tsg_pkg::F_PRESS;
          if (st_in.press_armed && st_in.repeat_count != 8'd255) begin
            st_out.repeat_count = st_in.repeat_count + 8'd1;
          end
          st_out.last_press_time = now;
          st_out.press_armed = 1'b1;
          st_out.tap_armed = 1'b0;
        end
      end else if (dur > 32'd250) begin
        st_out.pending_flags = st_out.pending_flags | tsg_pkg::F_HOLD;
      end
    end else begin
      if (mx3 > $signed({3'b0, st_in.pos_sum_x}) || mx3 < $signed({3'b0, st_in.neg_sum_x})) begin
        st_out.swipe_dx = mx[15:0];
      end
      if (my3 > $signed({3'b0, st_in.pos_sum_y}) || my3 < $signed({3'b0, st_in.neg_sum_y})) begin
        st_out.swipe_dy = 16'(-my);
      end
    end
    swipe_any = (st_out.swipe_dx != 16'sd0) || (st_out.swipe_dy != 16'sd0);
    if (rel) begin
      if (swipe_any) begin
        st_out.pending_flags = st_out.pending_flags | tsg_pkg::F_SWIPE;
        st_out.tap_armed = 1'b0;
        st_out.press_armed = 1'b0;
        st_out.repeat_count = 8'd0;
      end
    end else if (dur > 32'd1000 && st_in.pending_flags[2] && swipe_any) begin
      st_out.pending_flags = st_out.pending_flags | tsg_pkg::F_DRAG;
    end
  end

endmodule

// ----- rtl/tsg_track.sv -----
// ----------------------------------------------------------------------------
// tsg_track
// Touch state register, position decode and per-item state update.
// ----------------------------------------------------------------------------
module tsg_track (
  input  logic             clk,
  input  logic             rst,
  input  logic             advance,
  input  logic             command,
  input  logic [11:0]      electrodes,
  input  logic [31:0]      time_ms,
  input  tsg_pkg::cfg_t    cfg,
  output logic             emit,
  output tsg_pkg::result_t result
);

  tsg_pkg::state_t st;
  tsg_pkg::state_t st_next;
  tsg_pkg::state_t cls_in;
  tsg_pkg::state_t cls_out;

  logic        was;
  logic        now_held;
  logic [5:0]  nx;
  logic [5:0]  ny;
  logic [31:0] dur;
  logic [31:0] tap_gap;
  logic [31:0] press_gap;
  logic        tick_live;
  logic signed [6:0] dx;
  logic signed [6:0] dy;
  logic [16:0] sum_x;
  logic [16:0] sum_y;

  assign was = (st.cur_x != 6'd0) || (st.cur_y != 6'd0);
  assign nx = tsg_pkg::decode_axis(electrodes[7:0], tsg_pkg::X_ELECTRODES,
                                   $signed({5'b0, cfg.min_x}) - 10'sd1,
                                   $signed({5'b0, cfg.min_x}) - 10'sd2,
                                   $signed({4'b0, cfg.max_x}),
                                   $signed({5'b0, cfg.min_x}),
                                   $signed({4'b0, cfg.max_x}), cfg.invert_x);
  assign ny = tsg_pkg::decode_axis({4'b0, electrodes[11:8]}, tsg_pkg::Y_ELECTRODES,
                                   $signed({5'b0, cfg.min_y}),
                                   $signed({5'b0, cfg.min_y}) - 10'sd1,
                                   $signed({4'b0, cfg.max_y}) + 10'sd1,
                                   $signed({5'b0, cfg.min_y}),
                                   $signed({4'b0, cfg.max_y}), cfg.invert_y);
  assign now_held = (nx != 6'd0) || (ny != 6'd0);
  assign dur = time_ms - st.touch_time;
  assign tap_gap = time_ms - st.last_tap_time;
  assign press_gap = time_ms - st.last_press_time;
  assign tick_live = was && ((time_ms - st.held_time) > 32'd250);
  assign dx = $signed({1'b0, nx}) - $signed({1'b0, st.cur_x});
  assign dy = $signed({1'b0, ny}) - $signed({1'b0, st.cur_y});

  always_comb begin
    cls_in = st;
    sum_x = 17'd0;
    sum_y = 17'd0;
    if (command) begin
      cls_in.held_time = time_ms;
    end else begin
      cls_in.cur_x = nx;
      cls_in.cur_y = ny;
      if (!now_held) begin
        cls_in.pending_flags = tsg_pkg::F_REL;
        cls_in.release_time = time_ms;
      end else begin
        cls_in.pending_flags = tsg_pkg::F_MOVE;
        if (nx != 6'd0 && st.cur_x != 6'd0) begin
          if (dx < 7'sd0) begin
            sum_x = {1'b0, st.neg_sum_x} + 17'(unsigned'(-dx));
            cls_in.neg_sum_x = (sum_x > {1'b0, tsg_pkg::SUM_MAX}) ? tsg_pkg::SUM_MAX : sum_x[15:0];
          end else begin
            sum_x = {1'b0, st.pos_sum_x} + 17'(unsigned'(dx));
            cls_in.pos_sum_x = (sum_x > {1'b0, tsg_pkg::SUM_MAX}) ? tsg_pkg::SUM_MAX : sum_x[15:0];
          end
        end
        if (ny != 6'd0 && st.cur_y != 6'd0) begin
          if (dy < 7'sd0) begin
            sum_y = {1'b0, st.neg_sum_y} + 17'(unsigned'(-dy));
            cls_in.neg_sum_y = (sum_y > {1'b0, tsg_pkg::SUM_MAX}) ? tsg_pkg::SUM_MAX : sum_y[15:0];
          end else begin
            sum_y = {1'b0, st.pos_sum_y} + 17'(unsigned'(dy));
            cls_in.pos_sum_y = (sum_y > {1'b0, tsg_pkg::SUM_MAX}) ? tsg_pkg::SUM_MAX : sum_y[15:0];
          end
        end
      end
    end
  end

  tsg_classify u_classify (
    .st_in  (cls_in),
    .now    (time_ms),
    .dur    (dur),
    .st_out (cls_out)
  );

  always_comb begin
    st_next = st;
    emit = 1'b0;
    result.event_flags = cls_out.pending_flags;
    result.pos_x = cls_out.cur_x;
    result.pos_y = cls_out.cur_y;
    result.start_x = cls_out.begin_x;
    result.start_y = cls_out.begin_y;
    result.swipe_x = cls_out.swipe_dx;
    result.swipe_y = cls_out.swipe_dy;
    result.tap_count = cls_out.repeat_count;
    result.duration_ms = dur;
    if (command) begin
      if (tick_live) begin
        st_next = cls_out;
        if (cls_out.pending_flags != 8'd0) begin
          emit = 1'b1;
          st_next.pending_flags = 8'd0;
        end
      end
    end else if (!was && now_held) begin
      st_next.cur_x = nx;
      st_next.cur_y = ny;
      if (st.tap_armed && !(tap_gap >= 32'd50 && tap_gap <= 32'd1000)) begin
        st_next.tap_armed = 1'b0;
        st_next.repeat_count = 8'd0;
      end
      if (st.press_armed && !(press_gap >= 32'd50 && press_gap <= 32'd1000)) begin
        st_next.press_armed = 1'b0;
        st_next.repeat_count = 8'd0;
      end
      st_next.touch_time = time_ms;
      st_next.held_time = time_ms;
      st_next.release_time = 32'd0;
      st_next.pos_sum_x = 16'd0;
      st_next.pos_sum_y = 16'd0;
      st_next.neg_sum_x = 16'd0;
      st_next.neg_sum_y = 16'd0;
      st_next.swipe_dx = 16'sd0;
      st_next.swipe_dy = 16'sd0;
      st_next.begin_x = nx;
      st_next.begin_y = ny;
      st_next.pending_flags = 8'd0;
      emit = 1'b1;
      result.event_flags = tsg_pkg::F_TOUCH;
      result.pos_x = nx;
      result.pos_y = ny;
      result.start_x = nx;
      result.start_y = ny;
      result.swipe_x = 16'sd0;
      result.swipe_y = 16'sd0;
      result.tap_count = st_next.repeat_count;
      result.duration_ms = 32'd0;
    end else if (was && !now_held) begin
      st_next = cls_out;
      st_next.touch_time = 32'd0;
      st_next.pending_flags = 8'd0;
      emit = 1'b1;
    end else if (was && now_held) begin
      st_next = cls_out;
    end else begin
      st_next.cur_x = nx;
      st_next.cur_y = ny;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (advance) begin
      st <= st_next;
    end
  end

  a_emit_clears : assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> st.pending_flags == 8'd0)
    else $error("pending flags survive a result");
  a_release_clears : assert property (@(posedge clk) disable iff (rst)
    (advance && !command && was && !now_held) |=> st.touch_time == 32'd0)
    else $error("touch time kept after release");
  a_sum_bound : assert property (@(posedge clk) disable iff (rst)
    !st.pos_sum_x[15] && !st.neg_sum_x[15] && !st.pos_sum_y[15] && !st.neg_sum_y[15])
    else $error("motion sum above saturation limit");
  a_idle_no_result : assert property (@(posedge clk) disable iff (rst)
    (!command && !was && !now_held) |-> !emit)
    else $error("result while idle");

endmodule

// ----- rtl/touch_slider_gesture_recognizer.sv -----
// ----------------------------------------------------------------------------
// touch_slider_gesture_recognizer
// Top level: configuration registers, input register, result register.
// ----------------------------------------------------------------------------
// An item is taken into an input register, processed by the touch tracker and
// any result is loaded into the output register, so the block accepts one
// transfer per clock while the output register is free or being read; a held
// result stalls the input register. The touch tracker's state update sets this rate.
module touch_slider_gesture_recognizer (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [47:0]  s_tdata,   // electrodes[11:0], time_ms[43:12], zero pad
  input  logic [0:0]   s_tuser,   // command
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [103:0] m_tdata,   // event_flags, pos_x, pos_y, start_x, start_y,
                                  // swipe_x, swipe_y, tap_count, duration_ms
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [5:0]   cfg_data
);

  tsg_pkg::cfg_t    cfg;
  tsg_pkg::result_t result;
  tsg_pkg::result_t out_reg;

  logic        in_valid;
  logic        in_cmd;
  logic [11:0] in_el;
  logic [31:0] in_time;
  logic        advance;
  logic        emit;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.min_x <= 5'd2;
      cfg.max_x <= 6'd17;
      cfg.min_y <= 5'd1;
      cfg.max_y <= 6'd8;
      cfg.invert_x <= 1'b0;
      cfg.invert_y <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        tsg_pkg::REG_MIN_X:    cfg.min_x <= cfg_data[4:0];
        tsg_pkg::REG_MAX_X:    cfg.max_x <= cfg_data;
        tsg_pkg::REG_MIN_Y:    cfg.min_y <= cfg_data[4:0];
        tsg_pkg::REG_MAX_Y:    cfg.max_y <= cfg_data;
        tsg_pkg::REG_INVERT_X: cfg.invert_x <= cfg_data[0];
        tsg_pkg::REG_INVERT_Y: cfg.invert_y <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign advance = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd <= s_tuser[0];
      in_el <= s_tdata[11:0];
      in_time <= s_tdata[43:12];
    end
  end

  tsg_track u_track (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .command    (in_cmd),
    .electrodes (in_el),
    .time_ms    (in_time),
    .cfg        (cfg),
    .emit       (emit),
    .result     (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (m_tready) m_tvalid <= 1'b0;
      if (advance && emit) m_tvalid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_reg <= result;
    end
  end

  assign m_tdata = {out_reg.duration_ms, out_reg.tap_count, out_reg.swipe_y, out_reg.swipe_x,
                    out_reg.start_y, out_reg.start_x, out_reg.pos_y, out_reg.pos_x,
                    out_reg.event_flags};

endmodule
